### design/ctt_pkg.sv
package ctt_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_UNSUPPORTED  = 2'd1,
        ST_UNCALIBRATED = 2'd2,
        ST_SKEW         = 2'd3
    } ctt_status_t;

    // Configuration register indexes
    localparam int CFG_IDX_W = 8;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MULT   = 8'd0,
        CFG_SHIFT  = 8'd1,
        CFG_BOOT   = 8'd2,
        CFG_OFFSET = 8'd3
    } ctt_cfg_idx_t;

    // Clock ids
    localparam logic [3:0] CLK_REALTIME         = 4'd0;
    localparam logic [3:0] CLK_MONOTONIC        = 4'd1;
    localparam logic [3:0] CLK_MONOTONIC_RAW    = 4'd4;
    localparam logic [3:0] CLK_REALTIME_COARSE  = 4'd5;
    localparam logic [3:0] CLK_MONOTONIC_COARSE = 4'd6;
    localparam logic [3:0] CLK_BOOTTIME         = 4'd7;

    // Configuration register file contents
    typedef struct packed {
        logic [31:0] mult;
        logic [5:0]  shift;
        logic [63:0] boot;
        logic [63:0] offset;
    } ctt_cfg_t;

    // Classified request passed from front end to back end
    typedef struct packed {
        ctt_status_t status;
        logic        is_rt;
        logic [63:0] delta;
    } ctt_item_t;

    localparam logic [5:0] SHIFT_MAX = 6'd32;

    // Queue between front and back end
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Back end pipeline depth, output register included
    localparam int BACK_STAGES = 11;

    // Divide by 1e9 = 2^9 * 1953125; 1953125 handled by reciprocal multiply
    localparam logic [20:0] DIV_D       = 21'd1953125;
    localparam logic [19:0] RECIP_M     = 20'd562949;   // floor(2^40 / 1953125)
    localparam int          RECIP_SHIFT = 40;

    // Signed total biased to unsigned: v + 9223372037 * 1e9
    localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
    localparam logic [64:0] BIAS_ADD = 65'd145224192;
    localparam logic [35:0] SEC_BIAS = 36'd9223372037;

endpackage

### design/ctt_front.sv
module ctt_front (
    input  logic                clk,
    input  logic                rst_n,
    input  ctt_pkg::ctt_cfg_t   cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [3:0]          clock_id,
    input  logic [63:0]         counter_value,
    output logic                item_valid,
    output ctt_pkg::ctt_item_t  item,
    input  logic                item_ready
);

    logic               vld_reg;
    logic               vld_next;
    ctt_pkg::ctt_item_t item_reg;
    ctt_pkg::ctt_item_t item_next;

    // Classify the request: id check, calibration, then skew
    always_comb
    begin
        logic        rt;
        logic        mono;
        logic [64:0] diff;
        rt   = (clock_id == ctt_pkg::CLK_REALTIME) ||
               (clock_id == ctt_pkg::CLK_REALTIME_COARSE);
        mono = (clock_id == ctt_pkg::CLK_MONOTONIC) ||
               (clock_id == ctt_pkg::CLK_MONOTONIC_RAW) ||
               (clock_id == ctt_pkg::CLK_MONOTONIC_COARSE) ||
               (clock_id == ctt_pkg::CLK_BOOTTIME);
        diff = {1'b0, counter_value} - {1'b0, cfg.boot};
        item_next.is_rt = rt;
        item_next.delta = diff[63:0];
        if (!rt && !mono)
        begin
            item_next.status = ctt_pkg::ST_UNSUPPORTED;
        end
        else if (cfg.mult == 32'd0)
        begin
            item_next.status = ctt_pkg::ST_UNCALIBRATED;
        end
        else if (diff[64])
        begin
            item_next.status = ctt_pkg::ST_SKEW;
        end
        else
        begin
            item_next.status = ctt_pkg::ST_OK;
        end
    end

    // Single holding register; refills as soon as the queue takes its item
    assign in_ready = !vld_reg || item_ready;
    assign vld_next = in_ready ? in_valid : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = vld_reg;
    assign item       = item_reg;

endmodule

### design/ctt_fifo.sv
module ctt_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  ctt_pkg::ctt_item_t push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output ctt_pkg::ctt_item_t pop_item
);

    ctt_pkg::ctt_item_t            entry_reg [ctt_pkg::FIFO_DEPTH];
    logic [ctt_pkg::FIFO_AW-1:0]   wr_ptr_reg;
    logic [ctt_pkg::FIFO_AW-1:0]   wr_ptr_next;
    logic [ctt_pkg::FIFO_AW-1:0]   rd_ptr_reg;
    logic [ctt_pkg::FIFO_AW-1:0]   rd_ptr_next;
    logic [ctt_pkg::FIFO_CW-1:0]   count_reg;
    logic [ctt_pkg::FIFO_CW-1:0]   count_next;
    logic                          push;
    logic                          pop;

    assign push_ready = (count_reg != ctt_pkg::FIFO_CW'(ctt_pkg::FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = entry_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### design/ctt_back.sv
module ctt_back (
    input  logic               clk,
    input  logic               rst_n,
    input  ctt_pkg::ctt_cfg_t  cfg,
    input  logic               item_valid,
    output logic               item_ready,
    input  ctt_pkg::ctt_item_t item,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [34:0]        seconds,
    output logic [29:0]        nanoseconds
);

    logic                                adv;
    logic [ctt_pkg::BACK_STAGES-1:0]     vld_reg;
    logic [ctt_pkg::BACK_STAGES-1:0]     vld_next;
    ctt_pkg::ctt_status_t                st_reg [ctt_pkg::BACK_STAGES];

    // s1: partial products of the delta halves
    logic [63:0] prod_lo_reg, prod_hi_reg;
    logic [5:0]  sh1_reg;
    logic        rt1_reg;
    // s2: scaled sum
    logic [63:0] sum2_reg;
    logic        rt2_reg;
    // s3: total nanoseconds
    logic [63:0] tot3_reg;
    // s4: biased unsigned total
    logic [64:0] ub4_reg;
    // s5..s7: first quotient digit
    logic [56:0] p1_5_reg;
    logic [36:0] x1_5_reg, x1_6_reg;
    logic [18:0] nlo5_reg, nlo6_reg, nlo7_reg;
    logic [8:0]  lw5_reg, lw6_reg, lw7_reg, lw8_reg, lw9_reg, lw10_reg;
    logic [16:0] q1e6_reg, q1_7_reg, q1_8_reg, q1_9_reg, q1_10_reg;
    logic [37:0] qd1_6_reg;
    logic [20:0] r1_7_reg;
    // s8..s10: second quotient digit
    logic [59:0] p2_8_reg;
    logic [39:0] x2_8_reg, x2_9_reg;
    logic [19:0] q2e9_reg;
    logic [40:0] qd2_9_reg;
    logic [18:0] q2_10_reg;
    logic [20:0] r2_10_reg;
    // s11: output register
    logic [34:0] sec_reg;
    logic [29:0] ns_reg;

    // Whole pipeline moves unless the output holds an untaken result
    assign adv        = !vld_reg[ctt_pkg::BACK_STAGES-1] || out_ready;
    assign item_ready = adv;
    assign vld_next   = {vld_reg[ctt_pkg::BACK_STAGES-2:0], item_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    // Status travels alongside the data
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg[0] <= item.status;
            for (int i = 1; i < ctt_pkg::BACK_STAGES; i++)
            begin
                st_reg[i] <= st_reg[i-1];
            end
        end
    end

    // Datapath stages
    always_ff @(posedge clk)
    begin
        logic [5:0]  sh;
        logic [63:0] part_lo;
        logic [63:0] part_hi;
        logic [21:0] r1t;
        logic        c1;
        logic [21:0] r2t;
        logic        c2;
        logic [35:0] qall;
        logic [35:0] sec_full;
        if (adv)
        begin
            // s1: multiply both halves
            sh          = (cfg.shift > ctt_pkg::SHIFT_MAX) ? ctt_pkg::SHIFT_MAX : cfg.shift;
            prod_lo_reg <= 64'(item.delta[31:0]) * 64'(cfg.mult);
            prod_hi_reg <= 64'(item.delta[63:32]) * 64'(cfg.mult);
            sh1_reg     <= sh;
            rt1_reg     <= item.is_rt;

            // s2: align and add, modulo 2^64
            part_lo  = prod_lo_reg >> sh1_reg;
            part_hi  = prod_hi_reg << (ctt_pkg::SHIFT_MAX - sh1_reg);
            sum2_reg <= part_hi + part_lo;
            rt2_reg  <= rt1_reg;

            // s3: wall offset for realtime ids
            tot3_reg <= sum2_reg + (rt2_reg ? cfg.offset : 64'd0);

            // s4: bias so floor division works on an unsigned value
            ub4_reg <= {1'b0, tot3_reg ^ ctt_pkg::SIGN_BIT} + ctt_pkg::BIAS_ADD;

            // s5: reciprocal estimate of the high digit
            p1_5_reg <= 57'(ub4_reg[64:28]) * 57'(ctt_pkg::RECIP_M);
            x1_5_reg <= ub4_reg[64:28];
            nlo5_reg <= ub4_reg[27:9];
            lw5_reg  <= ub4_reg[8:0];

            // s6: back-multiply the estimate
            q1e6_reg  <= p1_5_reg[56:ctt_pkg::RECIP_SHIFT];
            qd1_6_reg <= 38'(p1_5_reg[56:ctt_pkg::RECIP_SHIFT]) * 38'(ctt_pkg::DIV_D);
            x1_6_reg  <= x1_5_reg;
            nlo6_reg  <= nlo5_reg;
            lw6_reg   <= lw5_reg;

            // s7: remainder with one-step correction
            r1t      = 22'(38'(x1_6_reg) - qd1_6_reg);
            c1       = (r1t >= 22'(ctt_pkg::DIV_D));
            r1_7_reg <= c1 ? 21'(r1t - 22'(ctt_pkg::DIV_D)) : r1t[20:0];
            q1_7_reg <= q1e6_reg + 17'(c1);
            nlo7_reg <= nlo6_reg;
            lw7_reg  <= lw6_reg;

            // s8: reciprocal estimate of the low digit
            p2_8_reg <= 60'({r1_7_reg, nlo7_reg}) * 60'(ctt_pkg::RECIP_M);
            x2_8_reg <= {r1_7_reg, nlo7_reg};
            q1_8_reg <= q1_7_reg;
            lw8_reg  <= lw7_reg;

            // s9: back-multiply
            q2e9_reg  <= p2_8_reg[59:ctt_pkg::RECIP_SHIFT];
            qd2_9_reg <= 41'(p2_8_reg[59:ctt_pkg::RECIP_SHIFT]) * 41'(ctt_pkg::DIV_D);
            x2_9_reg  <= x2_8_reg;
            q1_9_reg  <= q1_8_reg;
            lw9_reg   <= lw8_reg;

            // s10: remainder with one-step correction
            r2t       = 22'(41'(x2_9_reg) - qd2_9_reg);
            c2        = (r2t >= 22'(ctt_pkg::DIV_D));
            r2_10_reg <= c2 ? 21'(r2t - 22'(ctt_pkg::DIV_D)) : r2t[20:0];
            q2_10_reg <= 19'(q2e9_reg + 20'(c2));
            q1_10_reg <= q1_9_reg;
            lw10_reg  <= lw9_reg;

            // s11: remove bias from seconds; zero fields on error
            qall     = {q1_10_reg, q2_10_reg};
            sec_full = qall - ctt_pkg::SEC_BIAS;
            if (st_reg[ctt_pkg::BACK_STAGES-2] == ctt_pkg::ST_OK)
            begin
                sec_reg <= sec_full[34:0];
                ns_reg  <= {r2_10_reg, lw10_reg};
            end
            else
            begin
                sec_reg <= '0;
                ns_reg  <= '0;
            end
        end
    end

    assign out_valid   = vld_reg[ctt_pkg::BACK_STAGES-1];
    assign status      = st_reg[ctt_pkg::BACK_STAGES-1];
    assign seconds     = sec_reg;
    assign nanoseconds = ns_reg;

endmodule

### design/counter_to_timespec.sv
// Converts a raw cycle counter sample into seconds and nanoseconds for the
// requested clock id, using the programmed multiplier, shift, boot count and
// wall offset. One transaction is accepted per clock cycle while out_ready
// is held high; each result passes through the front-end classification
// register, the four-entry queue and the eleven-stage back-end pipeline,
// whose length is set by the 32x32 scale multiplies and the floor division
// by 1e9, done as two reciprocal-multiply digit steps with a back-multiply
// and correction each. Results leave in request order. Errors give seconds
// and nanoseconds of zero. Configuration writes are always accepted and
// must only be issued while no request is in flight.
module counter_to_timespec (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [3:0]                    clock_id,
    input  logic [63:0]                   counter_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic [34:0]                   seconds,
    output logic [29:0]                   nanoseconds,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ctt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data
);

    ctt_pkg::ctt_cfg_t  cfg_reg;
    logic               fr_valid;
    logic               fr_ready;
    ctt_pkg::ctt_item_t fr_item;
    logic               bk_valid;
    logic               bk_ready;
    ctt_pkg::ctt_item_t bk_item;

    // Configuration registers; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mult   <= '0;
            cfg_reg.shift  <= ctt_pkg::SHIFT_MAX;
            cfg_reg.boot   <= '0;
            cfg_reg.offset <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ctt_pkg::CFG_MULT:   cfg_reg.mult   <= cfg_data[31:0];
                ctt_pkg::CFG_SHIFT:  cfg_reg.shift  <= cfg_data[5:0];
                ctt_pkg::CFG_BOOT:   cfg_reg.boot   <= cfg_data;
                ctt_pkg::CFG_OFFSET: cfg_reg.offset <= cfg_data;
                default:             cfg_reg        <= cfg_reg;
            endcase
        end
    end

    ctt_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .clock_id      (clock_id),
        .counter_value (counter_value),
        .item_valid    (fr_valid),
        .item          (fr_item),
        .item_ready    (fr_ready)
    );

    ctt_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_item  (fr_item),
        .pop_valid  (bk_valid),
        .pop_ready  (bk_ready),
        .pop_item   (bk_item)
    );

    ctt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .item_valid  (bk_valid),
        .item_ready  (bk_ready),
        .item        (bk_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .seconds     (seconds),
        .nanoseconds (nanoseconds)
    );

endmodule

### design/ctt_checker.sv
module ctt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [34:0] seconds,
    input logic [29:0] nanoseconds
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) &&
        $stable(seconds) && $stable(nanoseconds))
        else $error("result changed while stalled");

    // Error results carry zero time fields
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ctt_pkg::ST_OK) |-> (seconds == '0) && (nanoseconds == '0))
        else $error("error result with non-zero time");

    // Nanosecond part stays below one second
    a_ns_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (nanoseconds < 30'd1000000000))
        else $error("nanoseconds out of range");

    // No result right out of reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid right after reset");

endmodule

bind counter_to_timespec ctt_checker u_ctt_checker (.*);
